// ----- rtl/efr_pkg.sv -----
// Shared types and constants for the escaped frame receiver.
`default_nettype none

package efr_pkg;

  // Widths of the data word and of the reported frame length.
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 6;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_CODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_CODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CODE = 2'd2;

  // Register values after reset.
  localparam logic [BYTE_W-1:0] START_CODE_RST  = 8'h02;
  localparam logic [BYTE_W-1:0] STOP_CODE_RST   = 8'h03;
  localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'h10;

  // Control byte values seen by the framing logic.
  typedef struct packed {
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] stop_code;
    logic [BYTE_W-1:0] escape_code;
  } cfg_t;

  // Receive and delivery states.
  typedef enum logic [2:0] {
    ST_WAIT,
    ST_RECV,
    ST_ESC,
    ST_READ,
    ST_LOAD,
    ST_EMPTY
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/efr_store.sv -----
// Payload buffer: one write port and one registered read port.
`default_nettype none

module efr_store #(
  parameter int MAX_PAYLOAD = 32
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1)-1:0] waddr,
  input  wire logic [efr_pkg::BYTE_W-1:0]          wdata,
  input  wire logic                                re,
  input  wire logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1)-1:0] raddr,
  output      logic [efr_pkg::BYTE_W-1:0]          rdata
);
  import efr_pkg::*;

  logic [BYTE_W-1:0] mem [MAX_PAYLOAD];

  // Write a payload word as it is received.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data is registered and holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/efr_ctrl.sv -----
// Framing state machine, checksum logic and output register.
`default_nettype none

module efr_ctrl #(
  parameter int MAX_PAYLOAD = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire efr_pkg::cfg_t                       cfg,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic [efr_pkg::BYTE_W-1:0]          rx_byte,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic [efr_pkg::BYTE_W-1:0]          payload_byte,
  output      logic                                empty_frame,
  output      logic                                last_of_frame,
  output      logic [efr_pkg::LEN_W-1:0]           frame_length,
  output      logic                                mem_we,
  output      logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1)-1:0] mem_waddr,
  output      logic [efr_pkg::BYTE_W-1:0]          mem_wdata,
  output      logic                                mem_re,
  output      logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1)-1:0] mem_raddr,
  input  wire logic [efr_pkg::BYTE_W-1:0]          mem_rdata
);
  import efr_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PAYLOAD);

  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic              staged, staged_next;
  logic [BYTE_W-1:0] held, held_next;
  logic [BYTE_W-1:0] xsum, xsum_next;
  logic [CW-1:0]     idx, idx_next;

  logic accept;
  logic out_free;
  logic do_take;
  logic do_clear;
  logic load_byte;
  logic load_empty;
  logic is_last;
  logic overflow;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign is_last  = ((idx + CW'(1)) == count);
  assign overflow = staged && (count >= MAX_CNT);

  // Input is held off while a checked frame is read out.
  assign in_stall = (state == ST_READ) || (state == ST_LOAD) || (state == ST_EMPTY);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WAIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state, frame commands and buffer reads.
  always_comb begin
    state_next = state;
    do_take    = 1'b0;
    do_clear   = 1'b0;
    load_byte  = 1'b0;
    load_empty = 1'b0;
    mem_re     = 1'b0;
    idx_next   = idx;
    unique case (state)
      ST_RECV: begin
        if (accept) begin
          priority if (rx_byte == cfg.escape_code) begin
            state_next = ST_ESC;
          end else if (rx_byte == cfg.start_code) begin
            do_clear = 1'b1;
          end else if (rx_byte == cfg.stop_code) begin
            state_next = ST_WAIT;
            idx_next   = '0;
            if (staged && (held == xsum)) begin
              state_next = (count == '0) ? ST_EMPTY : ST_READ;
            end
          end else begin
            do_take = 1'b1;
          end
        end
      end
      ST_ESC: begin
        if (accept) begin
          do_take    = 1'b1;
          state_next = ST_RECV;
        end
      end
      ST_READ: begin
        mem_re     = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          load_byte  = 1'b1;
          idx_next   = idx + CW'(1);
          state_next = is_last ? ST_WAIT : ST_READ;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          load_empty = 1'b1;
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (accept && (rx_byte == cfg.start_code)) begin
          do_clear   = 1'b1;
          state_next = ST_RECV;
        end
      end
      default: begin
        // An unknown code acts as waiting for a start word.
        state_next = ST_WAIT;
        if (accept && (rx_byte == cfg.start_code)) begin
          do_clear   = 1'b1;
          state_next = ST_RECV;
        end
      end
    endcase
  end

  // Staging of each received word: the held word moves into the buffer.
  always_comb begin
    count_next  = count;
    staged_next = staged;
    held_next   = held;
    xsum_next   = xsum;
    mem_we      = 1'b0;
    if (do_clear) begin
      count_next  = '0;
      staged_next = 1'b0;
      xsum_next   = '0;
    end else if (do_take) begin
      if (overflow) begin
        // A word past the buffer restarts the frame and is dropped.
        count_next  = '0;
        staged_next = 1'b0;
        xsum_next   = '0;
      end else begin
        if (staged) begin
          mem_we     = 1'b1;
          count_next = count + CW'(1);
          xsum_next  = xsum ^ held;
        end
        held_next   = rx_byte;
        staged_next = 1'b1;
      end
    end
  end

  assign mem_waddr = count[AW-1:0];
  assign mem_wdata = held;
  assign mem_raddr = idx[AW-1:0];

  // Frame registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      staged <= 1'b0;
      held   <= '0;
      xsum   <= '0;
      idx    <= '0;
    end else begin
      count  <= count_next;
      staged <= staged_next;
      held   <= held_next;
      xsum   <= xsum_next;
      idx    <= idx_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_byte || load_empty) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (load_byte) begin
      payload_byte  <= mem_rdata;
      empty_frame   <= 1'b0;
      last_of_frame <= is_last;
      frame_length  <= LEN_W'(count);
    end else if (load_empty) begin
      payload_byte  <= '0;
      empty_frame   <= 1'b1;
      last_of_frame <= 1'b1;
      frame_length  <= '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/escaped_frame_receiver.sv -----
// Top level of the escaped frame receiver: configuration registers and wiring.
`default_nettype none

// Receives a byte-stuffed link one word per cycle unless in_stall is high:
// a start code opens a frame, an escape code makes the next word literal, a
// stop code closes it, and the word just before stop is the XOR checksum of
// the payload. While receiving, one input word is taken every cycle. When a
// frame checks out, the input stalls while the payload is read back from the
// single buffer memory: each payload word is read from memory, then loaded
// into the output register once it is free; an empty frame loads one word
// once the output register is free. A finished result can wait in the output
// register while new words arrive. Frames with a bad checksum, or a stop with
// nothing received, give no output. Control codes are written through the
// cfg port while the block is idle; the user must ensure this, not the block.
module escaped_frame_receiver #(
  parameter int MAX_PAYLOAD = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [efr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [efr_pkg::BYTE_W-1:0]        cfg_data,
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic [efr_pkg::BYTE_W-1:0]        rx_byte,
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic [efr_pkg::BYTE_W-1:0]        payload_byte,
  output      logic                              empty_frame,
  output      logic                              last_of_frame,
  output      logic [efr_pkg::LEN_W-1:0]         frame_length
);
  import efr_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  cfg_t              cfg;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_code  <= START_CODE_RST;
      cfg.stop_code   <= STOP_CODE_RST;
      cfg.escape_code <= ESCAPE_CODE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_START_CODE:  cfg.start_code  <= cfg_data;
        REG_STOP_CODE:   cfg.stop_code   <= cfg_data;
        REG_ESCAPE_CODE: cfg.escape_code <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  efr_ctrl #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_byte  (payload_byte),
    .empty_frame   (empty_frame),
    .last_of_frame (last_of_frame),
    .frame_length  (frame_length),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  efr_store #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

// ----- rtl/efr_checker.sv -----
// Port-level assertions for the escaped frame receiver, with its bind.
`default_nettype none

module efr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] payload_byte,
  input wire logic       empty_frame,
  input wire logic       last_of_frame,
  input wire logic [5:0] frame_length
);

  // A stalled output word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(payload_byte) && $stable(last_of_frame))
    else $error("output word changed while stalled");

  // An empty frame is a single word with zero length.
  a_empty_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_frame |-> last_of_frame && (frame_length == 6'd0))
    else $error("empty frame word is malformed");

  // While a frame is still being delivered, no new input is taken.
  a_deliver_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_frame |-> in_stall)
    else $error("input taken in the middle of frame delivery");

endmodule

bind escaped_frame_receiver efr_checker u_efr_checker (.*);

`default_nettype wire
